@@ sv/mfq_pkg.sv @@
// shared types, constants and address helpers for the multilevel feedback queue scheduler
package mfq_pkg;

    localparam int NUM_LEVELS  = 4;
    localparam int QUEUE_DEPTH = 16;

    localparam int CFG_W    = 12;
    localparam int NEED_W   = 16;
    localparam int ID_W     = 16;
    localparam int TIME_W   = 32;
    localparam int SLICES_W = 8;
    localparam int LEVEL_W  = 2;

    localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH   = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int QUANT_W = CFG_W + NUM_LEVELS - 1;
    localparam int CMP_W   = (QUANT_W > NEED_W) ? QUANT_W : NEED_W;

    localparam logic [CFG_W-1:0] QUANTUM_RESET  = CFG_W'(20);
    localparam logic [ID_W-1:0]  FIRST_JOB      = ID_W'(1);
    localparam logic [ID_W-1:0]  LAST_JOB       = '1;
    localparam logic [SLICES_W-1:0] SLICES_MAX  = '1;

    typedef enum logic {
        CMD_ADMIT = 1'b0,
        CMD_RUN   = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_ADMIT = 2'd0,
        STAT_RAN   = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [NEED_W-1:0]   rem;
        logic [NEED_W-1:0]   total;
        logic [SLICES_W-1:0] slices;
    } entry_t;

    typedef struct packed {
        status_t             status;
        logic [ID_W-1:0]     job_id;
        logic [LEVEL_W-1:0]  level;
        logic [TIME_W-1:0]   start_time;
        logic [NEED_W-1:0]   slice_time;
        logic [NEED_W-1:0]   run_total;
        logic [SLICES_W-1:0] slice_count;
        logic                finished;
        logic [TIME_W-1:0]   end_time;
        logic [NEED_W-1:0]   remaining;
    } result_t;

    function automatic logic [ADDR_W-1:0] entry_addr(logic [LVL_W-1:0] lv,
                                                     logic [SLOT_W-1:0] slot);
        return ADDR_W'(ADDR_W'(lv) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(slot);
    endfunction

    function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] slot);
        return (slot == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : slot + 1'b1;
    endfunction

endpackage

@@ sv/mfq_ram.sv @@
// generic single-write, single-read ram with registered read data
module mfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/multilevel_feedback_queue_scheduler.sv @@
// top level of the multilevel feedback queue scheduler
// An admit request, if there is room, writes the new job to the tail of level 0 and
// registers its result at once. A run request goes through the IDLE and RUN states, as the
// job store ram has registered read data: the head entry of the highest non-empty level
// is read in IDLE, and in RUN the slice is computed and an unfinished job is written to
// the tail of the next lower level (or back to the bottom level). A request is accepted while
// the previous result waits in the output register as long as that register is being taken.
// The job store needs no clearing after reset: an entry is always written before it is read.
module multilevel_feedback_queue_scheduler (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration write: base_quantum
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [mfq_pkg::CFG_W-1:0]  cfg_data,
    // request
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,   // need_time
    input  logic [0:0]                 s_tuser,   // command
    // result
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // job_id, level, start_time, slice_time, run_total, slice_count, finished,
    // end_time, remaining, zero pad
    output logic [143:0]               m_tdata,
    output logic [1:0]                 m_tuser    // status
);

    import mfq_pkg::*;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   head_reg [NUM_LEVELS];
    logic [SLOT_W-1:0]   head_next [NUM_LEVELS];
    logic [SLOT_W-1:0]   tail_reg [NUM_LEVELS];
    logic [SLOT_W-1:0]   tail_next [NUM_LEVELS];
    logic [CNT_W-1:0]    count_reg [NUM_LEVELS];
    logic [CNT_W-1:0]    count_next [NUM_LEVELS];
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [ID_W-1:0]     next_job_reg, next_job_next;
    logic [CFG_W-1:0]    quantum_reg;
    logic [LVL_W-1:0]    lv_reg, lv_next;
    logic                out_valid_reg, out_valid_next;
    result_t             res_reg, res_next;

    logic                out_free;
    logic                accept;
    logic                found;
    logic [LVL_W-1:0]    sel_lv;
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    entry_t              ram_wr_data;
    logic                ram_rd_en;
    entry_t              ram_rd_data;

    logic [CMP_W-1:0]    quantum;
    logic                done;
    logic [NEED_W-1:0]   slice;
    logic [LVL_W-1:0]    dst_lv;
    entry_t              upd;
    logic [TIME_W-1:0]   end_time;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;

    // highest non-empty level
    always_comb
    begin
        found  = 1'b0;
        sel_lv = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                found  = 1'b1;
                sel_lv = LVL_W'(i);
            end
        end
    end

    // slice arithmetic on the entry read back from the store
    always_comb
    begin
        quantum  = CMP_W'(quantum_reg) << lv_reg;
        done     = CMP_W'(ram_rd_data.rem) <= quantum;
        slice    = done ? ram_rd_data.rem : NEED_W'(quantum);
        dst_lv   = (lv_reg == LVL_W'(NUM_LEVELS - 1)) ? lv_reg : lv_reg + 1'b1;
        end_time = time_reg + TIME_W'(slice);
        upd.id     = ram_rd_data.id;
        upd.rem    = ram_rd_data.rem - slice;
        upd.total  = ram_rd_data.total + slice;
        upd.slices = (ram_rd_data.slices == SLICES_MAX) ? ram_rd_data.slices
                                                         : ram_rd_data.slices + 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        time_next      = time_reg;
        next_job_next  = next_job_reg;
        lv_next        = lv_reg;
        out_valid_next = out_valid_reg && !m_tready;
        res_next       = res_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = entry_addr(dst_lv, tail_reg[dst_lv]);
        ram_wr_data    = upd;
        ram_rd_en      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    if (cmd_t'(s_tuser[0]) == CMD_ADMIT)
                    begin
                        out_valid_next = 1'b1;
                        if (total_reg >= CNT_W'(QUEUE_DEPTH))
                        begin
                            res_next.status = STAT_FULL;
                        end
                        else
                        begin
                            ram_wr_en          = 1'b1;
                            ram_wr_addr        = entry_addr('0, tail_reg[0]);
                            ram_wr_data.id     = next_job_reg;
                            ram_wr_data.rem    = s_tdata[NEED_W-1:0];
                            ram_wr_data.total  = '0;
                            ram_wr_data.slices = '0;
                            tail_next[0]       = next_slot(tail_reg[0]);
                            count_next[0]      = count_reg[0] + 1'b1;
                            total_next         = total_reg + 1'b1;
                            next_job_next      = (next_job_reg == LAST_JOB) ? FIRST_JOB
                                                                            : next_job_reg + 1'b1;
                            res_next.status    = STAT_ADMIT;
                            res_next.job_id    = next_job_reg;
                            res_next.remaining = s_tdata[NEED_W-1:0];
                        end
                    end
                    else if (!found)
                    begin
                        out_valid_next  = 1'b1;
                        res_next.status = STAT_EMPTY;
                    end
                    else
                    begin
                        // pop the head now, finish the slice when the entry arrives
                        ram_rd_en          = 1'b1;
                        head_next[sel_lv]  = next_slot(head_reg[sel_lv]);
                        count_next[sel_lv] = count_reg[sel_lv] - 1'b1;
                        lv_next            = sel_lv;
                        state_next         = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (done)
                begin
                    total_next = total_reg - 1'b1;
                end
                else
                begin
                    ram_wr_en          = 1'b1;
                    tail_next[dst_lv]  = next_slot(tail_reg[dst_lv]);
                    count_next[dst_lv] = count_reg[dst_lv] + 1'b1;
                end
                time_next            = end_time;
                out_valid_next       = 1'b1;
                res_next.status      = STAT_RAN;
                res_next.job_id      = upd.id;
                res_next.level       = LEVEL_W'(lv_reg);
                res_next.start_time  = time_reg;
                res_next.slice_time  = slice;
                res_next.run_total   = upd.total;
                res_next.slice_count = upd.slices;
                res_next.finished    = done;
                res_next.end_time    = end_time;
                res_next.remaining   = upd.rem;
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            total_reg     <= '0;
            time_reg      <= '0;
            next_job_reg  <= FIRST_JOB;
            quantum_reg   <= QUANTUM_RESET;
            lv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            time_reg      <= time_next;
            next_job_reg  <= next_job_next;
            lv_reg        <= lv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                quantum_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    mfq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (entry_addr(sel_lv, head_reg[sel_lv])),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {5'b0, res_reg.remaining, res_reg.end_time, res_reg.finished,
                       res_reg.slice_count, res_reg.run_total, res_reg.slice_time,
                       res_reg.start_time, res_reg.level, res_reg.job_id};

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the multilevel feedback queue scheduler
`timescale 1ns / 1ps

module testbench;

    import mfq_pkg::*;

    typedef struct packed {
        logic        cfg_en;
        logic [11:0] cfg_val;
        cmd_t        cmd;
        logic [15:0] need;
        logic        typed;
        result_t     fixed;
    } stim_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata   = '0;   // need_time
    logic [0:0]          s_tuser   = '0;   // command
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    // job_id, level, start_time, slice_time, run_total, slice_count, finished,
    // end_time, remaining, zero pad
    logic [143:0]        m_tdata;
    logic [1:0]          m_tuser;          // status

    // scheduler shadow state
    entry_t              job_mem [DEPTH];
    int                  q_head [NUM_LEVELS];
    int                  q_tail [NUM_LEVELS];
    int                  q_cnt  [NUM_LEVELS];
    int                  jobs_held;
    logic [TIME_W-1:0]   sys_clock;
    logic [ID_W-1:0]     next_id;
    logic [CFG_W-1:0]    quantum_cfg;
    int                  time_wraps = 0;
    int                  id_wraps   = 0;

    result_t             sched_exp_q [$];
    stim_row_t           dir_rows [$];

    bit                  quiet   = 1'b0;
    int                  rx_hold = 0;
    int                  n_err   = 0;
    int                  n_req   = 0;
    int                  n_res   = 0;
    int                  n_done  = 0;
    int                  stat_seen [4] = '{0, 0, 0, 0};

    always #10 clk = ~clk;

    multilevel_feedback_queue_scheduler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    function automatic void enqueue_job(int lv, entry_t e);
        job_mem[lv * QUEUE_DEPTH + q_tail[lv]] = e;
        q_tail[lv] = (q_tail[lv] + 1) % QUEUE_DEPTH;
        q_cnt[lv]++;
    endfunction

    // one request through the shadow scheduler
    function automatic result_t schedule_step(cmd_t cmd, logic [15:0] need);
        result_t     r;
        entry_t      e;
        int          lv;
        logic [31:0] q;
        logic [31:0] sl;
        logic [32:0] sum;
        logic        done;
        r = '0;
        if (cmd == CMD_ADMIT) begin
            if (jobs_held >= QUEUE_DEPTH) begin
                r.status = STAT_FULL;
                return r;
            end
            e.id     = next_id;
            e.rem    = need;
            e.total  = '0;
            e.slices = '0;
            enqueue_job(0, e);
            jobs_held++;
            r.status    = STAT_ADMIT;
            r.job_id    = next_id;
            r.remaining = need;
            if (next_id == LAST_JOB) begin
                next_id = FIRST_JOB;
                id_wraps++;
            end else begin
                next_id = next_id + 1'b1;
            end
            return r;
        end
        lv = 0;
        while (lv < NUM_LEVELS && q_cnt[lv] == 0)
            lv++;
        if (lv == NUM_LEVELS) begin
            r.status = STAT_EMPTY;
            return r;
        end
        e = job_mem[lv * QUEUE_DEPTH + q_head[lv]];
        q_head[lv] = (q_head[lv] + 1) % QUEUE_DEPTH;
        q_cnt[lv]--;
        q    = 32'(quantum_cfg) << lv;
        done = (32'(e.rem) <= q);
        sl   = done ? 32'(e.rem) : q;
        r.start_time = sys_clock;
        sum = {1'b0, sys_clock} + {1'b0, sl};
        if (sum[32])
            time_wraps++;
        sys_clock = sum[31:0];
        e.rem   = e.rem - 16'(sl);
        e.total = e.total + 16'(sl);
        if (e.slices != SLICES_MAX)
            e.slices = e.slices + 1'b1;
        if (done)
            jobs_held--;
        else
            enqueue_job((lv + 1 < NUM_LEVELS) ? lv + 1 : lv, e);
        r.status      = STAT_RAN;
        r.job_id      = e.id;
        r.level       = 2'(lv);
        r.slice_time  = 16'(sl);
        r.run_total   = e.total;
        r.slice_count = e.slices;
        r.finished    = done;
        r.end_time    = sys_clock;
        r.remaining   = e.rem;
        return r;
    endfunction

    function automatic string fmt_res(result_t x);
        return $sformatf({"st=%0d id=%0d lv=%0d start=%0d slice=%0d total=%0d cnt=%0d",
                          " fin=%0d end=%0d rem=%0d"},
                         x.status, x.job_id, x.level, x.start_time, x.slice_time,
                         x.run_total, x.slice_count, x.finished, x.end_time, x.remaining);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_need();
        int lim;
        lim = 3 * int'(quantum_cfg) + 1;
        if (lim > 65535)
            lim = 65535;
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, lim));
        endcase
    endfunction

    function automatic void add_row(cmd_t cmd, logic [15:0] need, logic cfg_en = 1'b0,
                                    logic [11:0] cfg_val = '0, logic typed = 1'b0,
                                    result_t fixed = '0);
        stim_row_t row;
        row.cfg_en  = cfg_en;
        row.cfg_val = cfg_val;
        row.cmd     = cmd;
        row.need    = need;
        row.typed   = typed;
        row.fixed   = fixed;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    task automatic send_req(cmd_t cmd, logic [15:0] need, logic typed = 1'b0,
                            result_t fixed = '0);
        result_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= need;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        r = schedule_step(cmd, need);
        sched_exp_q.insert(sched_exp_q.size(), typed ? fixed : r);
        n_req++;
    endtask

    task automatic hold_off(int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sched_exp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_quantum(logic [11:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid   <= 1'b0;
        quantum_cfg = v;
    endtask

    always @(posedge clk) begin : result_monitor
        result_t got;
        result_t want;
        string   bad;
        if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got.status      = status_t'(m_tuser);
            got.job_id      = m_tdata[15:0];
            got.level       = m_tdata[17:16];
            got.start_time  = m_tdata[49:18];
            got.slice_time  = m_tdata[65:50];
            got.run_total   = m_tdata[81:66];
            got.slice_count = m_tdata[89:82];
            got.finished    = m_tdata[90];
            got.end_time    = m_tdata[122:91];
            got.remaining   = m_tdata[138:123];
            n_res++;
            if (sched_exp_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result %0d: %s", n_res, fmt_res(got));
            end else begin
                want = sched_exp_q.pop_front();
                stat_seen[want.status]++;
                if (want.finished)
                    n_done++;
                bad = "";
                if (got.status      !== want.status)      bad = {bad, " status"};
                if (got.job_id      !== want.job_id)      bad = {bad, " job_id"};
                if (got.level       !== want.level)       bad = {bad, " level"};
                if (got.start_time  !== want.start_time)  bad = {bad, " start_time"};
                if (got.slice_time  !== want.slice_time)  bad = {bad, " slice_time"};
                if (got.run_total   !== want.run_total)   bad = {bad, " run_total"};
                if (got.slice_count !== want.slice_count) bad = {bad, " slice_count"};
                if (got.finished    !== want.finished)    bad = {bad, " finished"};
                if (got.end_time    !== want.end_time)    bad = {bad, " end_time"};
                if (got.remaining   !== want.remaining)   bad = {bad, " remaining"};
                if (bad != "") begin
                    n_err++;
                    if (n_err <= 10)
                        $display("result %0d wrong in%s\n  expected %s\n  actual   %s",
                                 n_res, bad, fmt_res(want), fmt_res(got));
                end
            end
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 2) == 0)
                rx_hold = pick_gap();
        end
    end

    initial begin : stimulus
        result_t     r;
        stim_row_t   row;
        logic [15:0] nd;
        logic [11:0] qv;
        int          bias;
        foreach (q_head[i]) begin
            q_head[i] = 0;
            q_tail[i] = 0;
            q_cnt[i]  = 0;
        end
        jobs_held   = 0;
        sys_clock   = '0;
        next_id     = FIRST_JOB;
        quantum_cfg = QUANTUM_RESET;
        bias        = 50;

        r = '0; r.status = STAT_EMPTY;
        add_row(CMD_RUN, 16'h1234, 1'b0, '0, 1'b1, r);
        r = '0; r.status = STAT_ADMIT; r.job_id = 16'd1;
        add_row(CMD_ADMIT, 16'h0000, 1'b0, '0, 1'b1, r);
        // zero need time: done at once with an empty slice
        r = '0; r.status = STAT_RAN; r.job_id = 16'd1; r.slice_count = 8'd1; r.finished = 1'b1;
        add_row(CMD_RUN, 16'hFFFF, 1'b0, '0, 1'b1, r);
        r = '0; r.status = STAT_ADMIT; r.job_id = 16'd2; r.remaining = 16'hFFFF;
        add_row(CMD_ADMIT, 16'hFFFF, 1'b0, '0, 1'b1, r);
        // zero quantum still demotes the job
        add_row(CMD_RUN, 16'h0000, 1'b1, 12'h000);
        add_row(CMD_RUN, 16'h0000, 1'b1, 12'h001);
        add_row(CMD_RUN, 16'h0000);
        // bottom level puts the job back on itself
        add_row(CMD_RUN, 16'h0000);
        add_row(CMD_RUN, 16'h5A5A, 1'b1, 12'hFFF);
        for (int i = 0; i < 15; i++) begin
            case (i)
                0:       nd = 16'h0001;
                1:       nd = 16'hFFFF;
                2:       nd = 16'h0000;
                3:       nd = 16'h5555;
                4:       nd = 16'hAAAA;
                default: nd = 16'($urandom_range(0, 65535));
            endcase
            add_row(CMD_ADMIT, nd);
        end
        // sixteen jobs held, so this one bounces
        r = '0; r.status = STAT_FULL;
        add_row(CMD_ADMIT, 16'd123, 1'b0, '0, 1'b1, r);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.cfg_en)
                set_quantum(row.cfg_val);
            send_req(row.cmd, row.need, row.typed, row.fixed);
            hold_off(pick_gap());
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       qv = 12'd1;
                1:       qv = 12'hFFF;
                2:       qv = QUANTUM_RESET;
                3:       qv = 12'($urandom_range(1, 63));
                4:       qv = 12'($urandom_range(1, 4095));
                default: qv = 12'($urandom_range(2, 300));
            endcase
            set_quantum(qv);
            quiet = (ph == 2);
            for (int k = 0; k < 130; k++) begin
                // shifting mix so the queues both fill up and run dry
                if (k % 32 == 0)
                    bias = $urandom_range(20, 80);
                if ($urandom_range(0, 99) < bias)
                    send_req(CMD_ADMIT, pick_need());
                else
                    send_req(CMD_RUN, 16'($urandom));
                hold_off(quiet ? 0 : pick_gap());
            end
        end
        quiet = 1'b0;

        set_quantum(12'hFFF);
        while (jobs_held != 0) begin
            send_req(CMD_RUN, 16'($urandom));
            hold_off(pick_gap());
        end

        // one job with more slices than the counter holds
        set_quantum(12'd1);
        send_req(CMD_ADMIT, 16'd2100);
        hold_off(pick_gap());
        while (jobs_held != 0) begin
            send_req(CMD_RUN, 16'($urandom));
            hold_off(pick_gap());
        end
        repeat (3) begin
            send_req(CMD_RUN, 16'($urandom));
            hold_off(pick_gap());
        end

        settle();
        repeat (10) @(posedge clk);
        $display("%0d requests, %0d results: %0d admits, %0d slices (%0d finished)",
                 n_req, n_res, stat_seen[STAT_ADMIT], stat_seen[STAT_RAN], n_done);
        $display("%0d idle runs, %0d full admits, quantum from 0 to 4095, %0s %0d, %0s %0d",
                 stat_seen[STAT_EMPTY], stat_seen[STAT_FULL], "job number wraps", id_wraps,
                 "clock wraps", time_wraps);
        if (n_err == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin : watchdog
        #100_000_000;
        $display("timeout with %0d results still outstanding", sched_exp_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
